// ----- src/tpm2_frame_receiver_macros.svh -----
// Assertion macros for the frame receiver.
// Used by the top level; the macros refer to the clk and rst_n signals in scope.
`ifndef TPM2_FRAME_RECEIVER_MACROS_SVH
`define TPM2_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TPM2FR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TPM2FR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tpm2fr_pkg.sv -----
// Shared types, codes and constants of the frame receiver.
// No dependencies; the stages, the parser, the top level and the testbench import it.
`timescale 1ns / 1ps

package tpm2fr_pkg;

  // Bytes in one report; bytes beyond this count are ignored.
  localparam int REPORT_BYTES = 64;
  localparam int POS_W        = $clog2(REPORT_BYTES + 1);

  localparam logic [7:0] SOF_BYTE   = 8'hC9;
  localparam logic [7:0] START_BYTE = 8'hDA;
  localparam logic [7:0] END_BYTE   = 8'h36;

  localparam logic [7:0] CMD_HELLO = 8'h11;
  localparam logic [7:0] CMD_BOOT  = 8'hB0;
  localparam logic [7:0] CMD_SCALE = 8'h5C;

  // Scale values need more payload bytes than this.
  localparam logic [5:0] SCALE_MIN_COUNT = 6'd15;
  localparam logic [5:0] MAX_PAYLOAD_RST = 6'd60;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_COMPLETE,
    EV_BAD_END,
    EV_TOO_LONG
  } event_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_HELLO,
    ACT_BOOT,
    ACT_SCALE
  } action_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       report_start;
  } item_t;

  typedef struct packed {
    logic       payload_valid;
    logic [5:0] payload_index;
    logic [7:0] payload_byte;
    event_t     frame_event;
    action_t    command_action;
    logic [5:0] frame_length;
  } result_t;

endpackage

// ----- src/tpm2fr_ifs.sv -----
// Valid/ready channel interfaces for the received bytes and the parse results.
// No dependencies.
`timescale 1ns / 1ps

interface tpm2fr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       report_start;

  modport source (output valid, output rx_byte, output report_start, input ready);
  modport sink   (input valid, input rx_byte, input report_start, output ready);
endinterface

interface tpm2fr_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [5:0] payload_index;
  logic [7:0] payload_byte;
  logic [1:0] frame_event;
  logic [1:0] command_action;
  logic [5:0] frame_length;

  modport source (output valid, output payload_valid, output payload_index,
                  output payload_byte, output frame_event, output command_action,
                  output frame_length, input ready);
  modport sink   (input valid, input payload_valid, input payload_index,
                  input payload_byte, input frame_event, input command_action,
                  input frame_length, output ready);
endinterface

// ----- src/tpm2fr_in_stage.sv -----
// Input register of the frame receiver: holds one item ahead of the parser.
// Depends on tpm2fr_pkg.
`timescale 1ns / 1ps

module tpm2fr_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tpm2fr_pkg::item_t   in_item,
  input  logic                take,
  output logic                held_valid,
  output tpm2fr_pkg::item_t   held_item
);
  import tpm2fr_pkg::*;

  logic  valid_r;
  item_t item_r;

  // The register may be refilled in the same cycle its item moves on.
  assign in_ready   = !valid_r || take;
  assign held_valid = valid_r;
  assign held_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- src/tpm2fr_parser.sv -----
// Frame parser: state registers and the per-byte next-state and result logic.
// Depends on tpm2fr_pkg.
`timescale 1ns / 1ps

module tpm2fr_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  tpm2fr_pkg::item_t     item,
  input  logic [5:0]            max_payload,
  output tpm2fr_pkg::result_t   res
);
  import tpm2fr_pkg::*;

  localparam logic [POS_W-1:0] POS_END = POS_W'(REPORT_BYTES);

  phase_t           phase_r, phase_nxt, phase_cur;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_cur;
  logic [7:0]       len_hi_r, len_hi_nxt;
  logic [5:0]       len_r, len_nxt;
  logic [5:0]       count_r, count_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  result_t          res_c;
  logic [7:0]       b;

  assign b   = item.rx_byte;
  assign res = res_c;

  always_comb begin
    phase_cur  = item.report_start ? PH_IDLE : phase_r;
    pos_cur    = item.report_start ? '0 : pos_r;
    phase_nxt  = phase_cur;
    pos_nxt    = pos_cur;
    len_hi_nxt = len_hi_r;
    len_nxt    = len_r;
    count_nxt  = count_r;
    cmd_nxt    = cmd_r;
    res_c      = '0;

    if (pos_cur < POS_END) begin
      pos_nxt = pos_cur + POS_W'(1);
      case (phase_cur)
        PH_IDLE: begin
          if (b == SOF_BYTE) phase_nxt = PH_START;
        end
        PH_START: begin
          if (b == START_BYTE) phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_hi_nxt = b;
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (len_hi_r == 8'd0 && b <= {2'b00, max_payload}) begin
            len_nxt   = b[5:0];
            count_nxt = '0;
            cmd_nxt   = '0;
            phase_nxt = PH_PAYLOAD;
          end else begin
            res_c.frame_event = EV_TOO_LONG;
            phase_nxt         = PH_IDLE;
          end
        end
        PH_PAYLOAD: begin
          if (count_r < len_r) begin
            if (count_r == 6'd0) cmd_nxt = b;
            res_c.payload_valid = 1'b1;
            res_c.payload_index = count_r;
            res_c.payload_byte  = b;
            count_nxt           = count_r + 6'd1;
          end else begin
            res_c.frame_length = count_r;
            if (b == END_BYTE) begin
              res_c.frame_event = EV_COMPLETE;
              if (cmd_r == CMD_HELLO && count_r != 6'd0) begin
                res_c.command_action = ACT_HELLO;
              end else if (cmd_r == CMD_BOOT) begin
                res_c.command_action = ACT_BOOT;
              end else if (cmd_r == CMD_SCALE && count_r > SCALE_MIN_COUNT) begin
                res_c.command_action = ACT_SCALE;
              end
            end else begin
              res_c.frame_event = EV_BAD_END;
            end
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      len_hi_r <= len_hi_nxt;
      len_r    <= len_nxt;
      count_r  <= count_nxt;
      cmd_r    <= cmd_nxt;
    end
  end

endmodule

// ----- src/tpm2fr_out_stage.sv -----
// Result register of the frame receiver: holds one result until it is taken.
// Depends on tpm2fr_pkg.
`timescale 1ns / 1ps

module tpm2fr_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load_valid,
  input  tpm2fr_pkg::result_t   load_res,
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tpm2fr_pkg::result_t   out_res
);
  import tpm2fr_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule

// ----- src/tpm2_frame_receiver.sv -----
// Frame receiver for 64-byte reports. Bytes enter on in_ch one item per
// clock while out_ch is not stalled, and every accepted item gives exactly
// one result item on out_ch, in order. An item passes an input register,
// the parse logic and a result register, which holds its result on out_ch
// until it is taken. A frame is 0xC9, 0xDA, a big-endian 16-bit length,
// the payload and the end byte 0x36. Payload bytes come out with their
// index; an oversized length gives a too-long event, and the byte after
// the payload gives the frame event and, on a complete frame, the command
// action. A report start flag drops any frame in progress, and bytes past
// the report length are ignored. The maximum payload length resets to 60;
// the user must write it through cfg_we/cfg_wdata only while the block is
// idle, which the block does not enforce. Depends on tpm2fr_pkg, tpm2fr_ifs,
// tpm2_frame_receiver_macros.svh and tpm2fr_in_stage, _parser and _out_stage.
`timescale 1ns / 1ps

module tpm2_frame_receiver (
  input  logic                clk,
  input  logic                rst_n,
  tpm2fr_in_if.sink           in_ch,
  tpm2fr_out_if.source        out_ch,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_wdata
);
  import tpm2fr_pkg::*;
  `include "tpm2_frame_receiver_macros.svh"

  logic [5:0] max_payload_r;
  item_t      in_item;
  item_t      held_item;
  logic       held_valid;
  logic       out_free;
  logic       step;
  result_t    parse_res;
  result_t    out_res;

  // Configuration register; the user must write it only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_payload_r <= cfg_wdata;
    end
  end

  assign in_item.rx_byte      = in_ch.rx_byte;
  assign in_item.report_start = in_ch.report_start;

  // The held item is parsed, and the parser state advances, in the cycle it
  // moves into the result register.
  assign step = held_valid && out_free;

  tpm2fr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .take       (out_free),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  tpm2fr_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (held_item),
    .max_payload (max_payload_r),
    .res         (parse_res)
  );

  tpm2fr_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (held_valid),
    .load_res   (parse_res),
    .free       (out_free),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_res    (out_res)
  );

  assign out_ch.payload_valid  = out_res.payload_valid;
  assign out_ch.payload_index  = out_res.payload_index;
  assign out_ch.payload_byte   = out_res.payload_byte;
  assign out_ch.frame_event    = out_res.frame_event;
  assign out_ch.command_action = out_res.command_action;
  assign out_ch.frame_length   = out_res.frame_length;

  // A payload byte never carries a frame event.
  `TPM2FR_ASSERT_NOW(a_payload_no_event, out_ch.valid && out_ch.payload_valid, out_res.frame_event == EV_NONE, "payload item carries a frame event")
  // A command action only accompanies a complete frame.
  `TPM2FR_ASSERT_NOW(a_action_on_complete, out_ch.valid && out_res.command_action != ACT_NONE, out_res.frame_event == EV_COMPLETE, "command action without complete frame")
  // With both registers full and the output stalled, no further item is taken.
  `TPM2FR_ASSERT_NOW(a_full_backpressure, held_valid && out_ch.valid && !out_ch.ready, !in_ch.ready, "input accepted while pipeline is full")
  // A held item always leaves when the result register is free.
  `TPM2FR_ASSERT_NEXT(a_step_loads_out, step, out_ch.valid, "parsed item did not reach the result register")

endmodule

// ----- sim/tpm2_frame_receiver_tb.sv -----
// Self-checking testbench for the frame receiver: directed frames, then random reports.
// A predictor in the testbench tracks the parser and checks every result item.
// Depends on tpm2fr_pkg, tpm2fr_ifs and the tpm2_frame_receiver top level.
`timescale 1ns / 1ps

module tpm2_frame_receiver_tb;
  import tpm2fr_pkg::*;

  // Cycles in which no item moves on either channel before the run is abandoned.
  localparam int STALL_LIMIT = 5000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [5:0] cfg_wdata;

  tpm2fr_in_if  in_ch ();
  tpm2fr_out_if out_ch ();

  tpm2_frame_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Parser state as the testbench sees it, plus its copy of the maximum length.
  phase_t     ph      = PH_IDLE;
  logic [15:0] len_q  = '0;
  logic [5:0] cnt_q   = '0;
  logic [7:0] cmd_q   = '0;
  int         rep_pos = 0;
  logic [5:0] max_len = MAX_PAYLOAD_RST;

  // Parse results still owed by the block, oldest first.
  result_t parse_q[$];

  // Sender bookkeeping: position within the current report and the flag for
  // the next item, which marks it as the first byte of a new report.
  int tx_pos       = 0;
  bit new_report   = 1'b0;
  int sent_cnt     = 0;
  int result_cnt   = 0;
  int mismatch_cnt = 0;
  int idle_cycles  = 0;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int tx_idle_pct  = 6;
  int rx_stall_pct = 57;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the result of one accepted byte and advances the parser state.
  function automatic result_t parse_byte(input logic [7:0] b, input logic start);
    result_t r;
    r = '0;
    // A new report always drops whatever frame was in progress.
    if (start) begin
      ph      = PH_IDLE;
      rep_pos = 0;
    end
    // Bytes beyond the end of the report leave the parser untouched.
    if (rep_pos < REPORT_BYTES) begin
      rep_pos++;
      case (ph)
        PH_IDLE: begin
          if (b == SOF_BYTE) ph = PH_START;
        end
        PH_START: begin
          // Anything other than the start byte is skipped while we wait.
          if (b == START_BYTE) ph = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_q = {b, 8'h00};
          ph    = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_q = {len_q[15:8], b};
          if (len_q <= 16'(max_len)) begin
            // The command is cleared here, so an empty frame carries none.
            cnt_q = '0;
            cmd_q = '0;
            ph    = PH_PAYLOAD;
          end else begin
            r.frame_event = EV_TOO_LONG;
            ph            = PH_IDLE;
          end
        end
        PH_PAYLOAD: begin
          if (16'(cnt_q) < len_q) begin
            if (cnt_q == 6'd0) cmd_q = b;
            r.payload_valid = 1'b1;
            r.payload_index = cnt_q;
            r.payload_byte  = b;
            cnt_q           = cnt_q + 6'd1;
          end else begin
            // This is the byte after the payload, which must be the end byte.
            r.frame_length = cnt_q;
            if (b == END_BYTE) begin
              r.frame_event = EV_COMPLETE;
              if (cmd_q == CMD_HELLO && cnt_q != 6'd0)
                r.command_action = ACT_HELLO;
              else if (cmd_q == CMD_BOOT)
                r.command_action = ACT_BOOT;
              else if (cmd_q == CMD_SCALE && cnt_q > SCALE_MIN_COUNT)
                r.command_action = ACT_SCALE;
            end else begin
              r.frame_event = EV_BAD_END;
            end
            ph = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t ns: result %0d, %s: got %h, expected %h", $time, result_cnt, what,
             got, want);
    mismatch_cnt++;
  endtask

  // Acceptance monitor and result checker. Both handshakes are sampled at the
  // rising edge, before any nonblocking update of that edge has landed, so the
  // values seen are the ones the block itself acted upon. Expectations are
  // queued before results are taken off, which keeps the order right even if
  // a result were to leave in the cycle its item arrived.
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        parse_q.push_back(parse_byte(in_ch.rx_byte, in_ch.report_start));
      if (out_ch.valid && out_ch.ready) begin
        if (parse_q.size() == 0) begin
          report_mismatch("result item with nothing expected", '0, '0);
        end else begin
          want = parse_q.pop_front();
          if (out_ch.payload_valid !== want.payload_valid)
            report_mismatch("payload_valid", out_ch.payload_valid, want.payload_valid);
          if (out_ch.payload_index !== want.payload_index)
            report_mismatch("payload_index", out_ch.payload_index, want.payload_index);
          if (out_ch.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", out_ch.payload_byte, want.payload_byte);
          if (out_ch.frame_event !== want.frame_event)
            report_mismatch("frame_event", out_ch.frame_event, want.frame_event);
          if (out_ch.command_action !== want.command_action)
            report_mismatch("command_action", out_ch.command_action, want.command_action);
          if (out_ch.frame_length !== want.frame_length)
            report_mismatch("frame_length", out_ch.frame_length, want.frame_length);
        end
        result_cnt++;
      end
    end
  end

  // Watchdog: the run is abandoned once nothing has moved for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver stalls at random, at the rate of the current phase.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offers one byte, after a random number of idle cycles, and returns at the
  // edge where it is taken. Valid stays high so that back-to-back items flow.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.rx_byte      <= b;
    in_ch.report_start <= new_report;
    tx_pos = new_report ? 1 : tx_pos + 1;
    // Bytes past the end of a report are ignored by the block and not counted.
    if (tx_pos <= REPORT_BYTES) sent_cnt++;
    new_report = 1'b0;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Sends one frame. The length field and the number of payload bytes sent
  // are separate so that oversized and truncated frames can be built; stray
  // bytes may be slipped in between the first and second header bytes.
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len_field,
                            input int body, input bit has_tail, input logic [7:0] tail,
                            input bit stray);
    logic [7:0] junk;
    send_byte(SOF_BYTE);
    if (stray) begin
      repeat ($urandom_range(3, 1)) begin
        junk = 8'($urandom);
        if (junk == START_BYTE) junk ^= 8'h01;
        send_byte(junk);
      end
    end
    send_byte(START_BYTE);
    send_byte(len_field[15:8]);
    send_byte(len_field[7:0]);
    for (int i = 0; i < body; i++) send_byte(i == 0 ? cmd : 8'($urandom));
    if (has_tail) send_byte(tail);
  endtask

  // Lets the sender go quiet until every owed result has arrived, with some margin.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (parse_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the maximum payload length while the block is quiet.
  task automatic set_max_len(input logic [5:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    max_len = v;
  endtask

  // One random piece of a report: mostly a well-formed frame with random
  // content, otherwise an oversized, badly ended or truncated frame, or noise.
  task automatic send_random_unit();
    int plen, kind, sel, top;
    logic [7:0] cmd, tail;
    logic [15:0] big;
    top  = (max_len < 8) ? max_len : 8;
    plen = $urandom_range(top, 0);
    sel  = $urandom_range(99);
    if (sel < 20 && max_len >= 16)
      plen = $urandom_range((max_len < 24) ? max_len : 24, 16);
    else if (sel < 30)
      plen = $urandom_range(max_len, 0);
    sel = $urandom_range(9);
    cmd = (sel < 3) ? CMD_HELLO : (sel < 5) ? CMD_BOOT : (sel < 7) ? CMD_SCALE :
          8'($urandom);
    kind = $urandom_range(99);
    if (kind < 75) begin
      send_frame(cmd, 16'(plen), plen, 1'b1, END_BYTE, $urandom_range(9) == 0);
    end else if (kind < 80) begin
      // Just over the limit half the time, anything above it otherwise.
      big = $urandom_range(1) ? 16'(max_len) + 16'd1 :
            16'($urandom_range(65535, int'(max_len) + 1));
      send_frame(cmd, big, 0, 1'b0, 8'h00, 1'b0);
    end else if (kind < 85) begin
      tail = 8'($urandom);
      if (tail == END_BYTE) tail ^= 8'h80;
      send_frame(cmd, 16'(plen), plen, 1'b1, tail, 1'b0);
    end else if (kind < 90) begin
      send_frame(cmd, 16'(plen), $urandom_range(plen, 0), 1'b0, 8'h00, 1'b0);
    end else begin
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
    end
  endtask

  // Directed: an empty frame completes, with no command since none was sent.
  task automatic test_empty_frame();
    new_report = 1'b1;
    send_frame(8'h00, 16'h0000, 0, 1'b1, END_BYTE, 1'b0);
  endtask

  // Directed: hello with a one-byte payload, with stray bytes while the
  // parser waits for the second header byte.
  task automatic test_hello_after_stray();
    send_frame(CMD_HELLO, 16'h0001, 1, 1'b1, END_BYTE, 1'b1);
  endtask

  // Directed: the largest length field is refused at once.
  task automatic test_too_long();
    send_frame(8'h00, 16'hFFFF, 0, 1'b0, 8'h00, 1'b0);
  endtask

  // Directed: a bootloader frame whose end byte is wrong.
  task automatic test_bad_end();
    send_frame(CMD_BOOT, 16'h0001, 1, 1'b1, 8'hFF, 1'b0);
  endtask

  // Directed: a new report arrives in the middle of a frame. The frame is
  // dropped silently, so the end byte that follows is just idle noise. The
  // sender then waits for every owed result before going on.
  task automatic test_cut_by_report();
    send_frame(CMD_SCALE, 16'h0002, 0, 1'b0, 8'h00, 1'b0);
    new_report = 1'b1;
    send_byte(END_BYTE);
    drain();
  endtask

  // Random reports at a given maximum payload length. Most reports are the
  // full 64 bytes; some are cut short by the next report, and some run past
  // their end without a new report flag, so those bytes must be ignored.
  task automatic test_random_reports(input logic [5:0] limit_len, input int n_items);
    int goal, mode, report_len;
    set_max_len(limit_len);
    goal = sent_cnt + n_items;
    while (sent_cnt < goal) begin
      mode       = $urandom_range(7);
      report_len = (mode == 0) ? REPORT_BYTES + $urandom_range(8, 1) :
                   (mode == 1) ? $urandom_range(REPORT_BYTES - 1, 4) : REPORT_BYTES;
      new_report = 1'b1;
      do send_random_unit(); while (tx_pos < report_len);
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.rx_byte      <= 8'h00;
    in_ch.report_start <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= 6'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items run with the sender mostly busy and the receiver stalling.
    test_empty_frame();
    test_hello_after_stray();
    test_too_long();
    test_bad_end();
    test_cut_by_report();

    // Sender rarely idles, receiver stalls often.
    test_random_reports(MAX_PAYLOAD_RST, 300);
    test_random_reports(6'd63, 300);

    // The other way round, including a limit of zero where only empty frames pass.
    tx_idle_pct  = 57;
    rx_stall_pct = 6;
    test_random_reports(6'd0, 200);
    test_random_reports(6'd16, 200);
    test_random_reports(6'($urandom), 200);

    // Full rate on both sides.
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    test_random_reports(6'd63, 300);
    test_random_reports(6'($urandom), 200);
    test_random_reports(MAX_PAYLOAD_RST, 150);

    drain();
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/tpm2fr_pkg.sv
src/tpm2fr_ifs.sv
src/tpm2fr_in_stage.sv
src/tpm2fr_parser.sv
src/tpm2fr_out_stage.sv
src/tpm2_frame_receiver.sv
sim/tpm2_frame_receiver_tb.sv
